### rtl/core/bcl_pkg.sv
// bcl_pkg: shared types and constants for the button click / long press core
// used by bcl_eval and button_click_long_press_debouncer_core
package bcl_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgW-1:0] DebounceRst  = 16'd30;
  localparam logic [CfgW-1:0] LongPressRst = 16'd800;
  localparam logic [CfgW-1:0] CooldownRst  = 16'd250;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEBOUNCE   = 2'd0,
    REG_LONG_PRESS = 2'd1,
    REG_COOLDOWN   = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    KIND_POLL  = 1'b0,
    KIND_RESET = 1'b1
  } kind_t;

  typedef struct packed {
    logic [CfgW-1:0] debounce_time;
    logic [CfgW-1:0] long_press_time;
    logic [CfgW-1:0] click_cooldown;
  } cfg_t;

  typedef struct packed {
    logic             raw_last;
    logic             stable_level;
    logic [TimeW-1:0] change_time;
    logic             is_pressing;
    logic [TimeW-1:0] press_begin;
    logic             long_done;
    logic [TimeW-1:0] click_time;
    logic             wait_release;
  } btn_state_t;

  typedef struct packed {
    kind_t            kind;
    logic             pin_level;
    logic [TimeW-1:0] now_ms;
  } item_t;

  typedef struct packed {
    logic click;
    logic long_press;
  } result_t;

endpackage

### rtl/core/button_click_long_press_debouncer_core.sv
// button_click_long_press_debouncer_core: debounced click and long press detection
// item_r is the input register and res_r the result register; throughput one transaction
// per cycle unless out_tready stalls, set by the single state update between them
// rst_n (synchronous, active low) restores default config and released button state
// depends on bcl_pkg and bcl_eval
module button_click_long_press_debouncer_core import bcl_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [39:0]        in_tdata,   // pin_level, now_ms[31:0], zero pad
  input  logic               in_tuser,   // kind
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [7:0]         out_tdata,  // click, long_press, zero pad
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_wdata
);

  cfg_t       cfg_r;
  btn_state_t st_r;
  btn_state_t st_nxt;
  item_t      item_r;
  logic       item_vld_r;
  logic       out_vld_r;
  result_t    res_r;
  result_t    res_nxt;
  logic       advance;

  assign advance    = item_vld_r && (!out_vld_r || out_tready);
  assign in_tready  = !item_vld_r || advance;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'b0, res_r.long_press, res_r.click};

  bcl_eval u_eval (
    .item   (item_r),
    .st     (st_r),
    .cfg    (cfg_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_time   <= DebounceRst;
      cfg_r.long_press_time <= LongPressRst;
      cfg_r.click_cooldown  <= CooldownRst;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE:   cfg_r.debounce_time   <= cfg_wdata;
        REG_LONG_PRESS: cfg_r.long_press_time <= cfg_wdata;
        REG_COOLDOWN:   cfg_r.click_cooldown  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
      st_r       <= '{raw_last: 1'b1, stable_level: 1'b1, default: '0};
    end else begin
      if (in_tready) begin
        item_vld_r <= in_tvalid;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
        st_r      <= st_nxt;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.kind      <= kind_t'(in_tuser);
      item_r.pin_level <= in_tdata[0];
      item_r.now_ms    <= in_tdata[32:1];
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

endmodule

### rtl/core/bcl_eval.sv
// bcl_eval: next button state and result for one registered item
// depends on bcl_pkg
module bcl_eval import bcl_pkg::*; (
  input  item_t      item,
  input  btn_state_t st,
  input  cfg_t       cfg,
  output btn_state_t st_nxt,
  output result_t    res
);

  logic [TimeW-1:0] db_elapsed;
  logic [TimeW-1:0] cd_elapsed;
  logic [TimeW-1:0] lp_elapsed;

  always_comb begin
    st_nxt     = st;
    res        = '0;
    db_elapsed = '0;
    cd_elapsed = '0;
    lp_elapsed = '0;
    if (item.kind == KIND_RESET) begin
      st_nxt.raw_last     = 1'b1;
      st_nxt.stable_level = 1'b1;
      st_nxt.change_time  = item.now_ms;
      st_nxt.is_pressing  = 1'b0;
      st_nxt.press_begin  = '0;
      st_nxt.long_done    = 1'b0;
      st_nxt.click_time   = item.now_ms;
      st_nxt.wait_release = 1'b0;
    end else if (st.wait_release) begin
      if (item.pin_level) begin
        st_nxt.wait_release = 1'b0;
        st_nxt.raw_last     = 1'b1;
        st_nxt.stable_level = 1'b1;
        st_nxt.change_time  = item.now_ms;
      end
    end else begin
      if (item.pin_level != st.raw_last) begin
        st_nxt.raw_last    = item.pin_level;
        st_nxt.change_time = item.now_ms;
      end
      db_elapsed = item.now_ms - st_nxt.change_time;
      cd_elapsed = item.now_ms - st.click_time;
      if ((db_elapsed > {{(TimeW-CfgW){1'b0}}, cfg.debounce_time}) &&
          (st.stable_level != st_nxt.raw_last)) begin
        st_nxt.stable_level = st_nxt.raw_last;
        if (!st_nxt.raw_last) begin
          st_nxt.is_pressing = 1'b1;
          st_nxt.press_begin = item.now_ms;
          st_nxt.long_done   = 1'b0;
        end else begin
          if (st.is_pressing && !st.long_done &&
              (cd_elapsed > {{(TimeW-CfgW){1'b0}}, cfg.click_cooldown})) begin
            res.click         = 1'b1;
            st_nxt.click_time = item.now_ms;
          end
          st_nxt.is_pressing = 1'b0;
        end
      end
      lp_elapsed = item.now_ms - st_nxt.press_begin;
      if (st_nxt.is_pressing && !st_nxt.long_done &&
          (lp_elapsed >= {{(TimeW-CfgW){1'b0}}, cfg.long_press_time})) begin
        res.long_press      = 1'b1;
        st_nxt.long_done    = 1'b1;
        st_nxt.wait_release = 1'b1;
      end
    end
  end

endmodule

### sim/button_click_long_press_debouncer_core_tb.sv
// testbench for button_click_long_press_debouncer_core: stream driver, monitor and
// a cycle-free predictor of click and long press events checked result by result
// depends on bcl_pkg and the core rtl
module button_click_long_press_debouncer_core_tb import bcl_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [39:0]        in_tdata = '0;   // pin_level, now_ms[31:0], zero pad
  logic               in_tuser = 1'b0; // kind
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [7:0]         out_tdata;       // click, long_press, zero pad
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0]    cfg_wdata = '0;

  button_click_long_press_debouncer_core dut (.*);

  always #10 clk = ~clk;

  item_t       pending[$];
  result_t     press_results[$];
  cfg_t        cfg_now;
  btn_state_t  btn;
  logic [31:0] clock_ms = '0;
  int unsigned pushed = 0;
  int unsigned bad_count = 0;
  int unsigned hold_asks = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  logic        calm = 1'b0;
  logic        in_took = 1'b0;

  function automatic void clear_button(logic [31:0] t);
    btn = '0;
    btn.raw_last = 1'b1;
    btn.stable_level = 1'b1;
    btn.change_time = t;
    btn.click_time = t;
  endfunction

  function automatic result_t debounce_step(item_t it);
    result_t     r;
    logic [31:0] since_change;
    logic [31:0] since_click;
    logic [31:0] held_for;
    r = '0;
    if (it.kind == KIND_RESET) begin
      clear_button(it.now_ms);
    end else if (btn.wait_release) begin
      if (it.pin_level) begin
        btn.wait_release = 1'b0;
        btn.raw_last = 1'b1;
        btn.stable_level = 1'b1;
        btn.change_time = it.now_ms;
      end
    end else begin
      if (it.pin_level != btn.raw_last) begin
        btn.raw_last = it.pin_level;
        btn.change_time = it.now_ms;
      end
      since_change = it.now_ms - btn.change_time;
      if (since_change > {16'd0, cfg_now.debounce_time} &&
          btn.stable_level != btn.raw_last) begin
        btn.stable_level = btn.raw_last;
        if (!btn.stable_level) begin
          btn.is_pressing = 1'b1;
          btn.press_begin = it.now_ms;
          btn.long_done = 1'b0;
        end else begin
          since_click = it.now_ms - btn.click_time;
          if (btn.is_pressing && !btn.long_done &&
              since_click > {16'd0, cfg_now.click_cooldown}) begin
            r.click = 1'b1;
            btn.click_time = it.now_ms;
          end
          btn.is_pressing = 1'b0;
        end
      end
      held_for = it.now_ms - btn.press_begin;
      if (btn.is_pressing && !btn.long_done &&
          held_for >= {16'd0, cfg_now.long_press_time}) begin
        r.long_press = 1'b1;
        btn.long_done = 1'b1;
        btn.wait_release = 1'b1;
      end
    end
    return r;
  endfunction

  // input side: offer queued items, idle now and then
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_took) begin
      if (pending.size() != 0 && (calm || $urandom_range(0, 99) >= 6)) begin
        in_tvalid <= 1'b1;
        in_tdata  <= {7'd0, pending[0].now_ms, pending[0].pin_level};
        in_tuser  <= pending[0].kind;
        void'(pending.pop_front());
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result side: random stalls plus long hold-offs on request
  always @(negedge clk) begin
    if (hold_seen != hold_asks) begin
      hold_seen  <= hold_asks;
      hold_left  <= 300;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(0, 99) >= 6);
    end
  end

  always @(posedge clk) begin : check_side
    item_t   cur;
    result_t want;
    in_took <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      cur.kind = kind_t'(in_tuser);
      cur.pin_level = in_tdata[0];
      cur.now_ms = in_tdata[32:1];
      press_results.push_back(debounce_step(cur));
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (press_results.size() == 0) begin
        if (bad_count < 10)
          $display("unexpected result transaction: click=%b long_press=%b",
                   out_tdata[0], out_tdata[1]);
        bad_count++;
      end else begin
        want = press_results.pop_front();
        if (out_tdata[0] !== want.click || out_tdata[1] !== want.long_press) begin
          if (bad_count < 10)
            $display("mismatch: expected click=%b long_press=%b, got click=%b long_press=%b",
                     want.click, want.long_press, out_tdata[0], out_tdata[1]);
          bad_count++;
        end
      end
    end
  end

  task automatic push_item(kind_t k, logic pin, logic [31:0] t);
    item_t it;
    it.kind = k;
    it.pin_level = pin;
    it.now_ms = t;
    pending.push_back(it);
    pushed++;
  endtask

  task automatic drain();
    while (pending.size() != 0 || in_tvalid || press_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CfgW-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_DEBOUNCE:   cfg_now.debounce_time = val;
      REG_LONG_PRESS: cfg_now.long_press_time = val;
      default:        cfg_now.click_cooldown = val;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(int unsigned db, int unsigned lp, int unsigned cd);
    drain();
    write_reg(REG_DEBOUNCE, db[CfgW-1:0]);
    write_reg(REG_LONG_PRESS, lp[CfgW-1:0]);
    write_reg(REG_COOLDOWN, cd[CfgW-1:0]);
  endtask

  // press with bounce, hold short or long, release with bounce
  task automatic gesture();
    int unsigned db, lp, cd, stride, span, el, d;
    db = cfg_now.debounce_time;
    lp = cfg_now.long_press_time;
    cd = cfg_now.click_cooldown;
    stride = (db + lp + cd) / 10 + 1;
    repeat ($urandom_range(0, 3)) begin
      clock_ms += $urandom_range(0, db);
      push_item(KIND_POLL, 1'($urandom_range(0, 1)), clock_ms);
    end
    span = db + $urandom_range(0, lp + lp / 2 + 2);
    el = 0;
    while (el <= span) begin
      d = $urandom_range(1, stride);
      el += d;
      clock_ms += d;
      push_item(KIND_POLL, 1'b0, clock_ms);
    end
    repeat ($urandom_range(0, 3)) begin
      clock_ms += $urandom_range(0, db);
      push_item(KIND_POLL, 1'($urandom_range(0, 1)), clock_ms);
    end
    span = db + $urandom_range(0, cd + db / 2 + 2);
    el = 0;
    while (el <= span) begin
      d = $urandom_range(1, stride);
      el += d;
      clock_ms += d;
      push_item(KIND_POLL, 1'b1, clock_ms);
    end
  endtask

  task automatic random_items(int unsigned n_items);
    int unsigned goal;
    goal = pushed + n_items;
    while (pushed < goal) begin
      case ($urandom_range(0, 19))
        0: push_item(KIND_RESET, 1'($urandom_range(0, 1)), clock_ms);
        1: push_item(KIND_POLL, 1'($urandom_range(0, 1)), $urandom());
        2: clock_ms -= $urandom_range(0, cfg_now.debounce_time + 20);
        default: gesture();
      endcase
    end
  endtask

  initial begin
    cfg_now.debounce_time = DebounceRst;
    cfg_now.long_press_time = LongPressRst;
    cfg_now.click_cooldown = CooldownRst;
    clear_button(32'd0);
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // default settings: debounce edge, cooldown, click, long press, wrap
    push_item(KIND_RESET, 1'b0, 32'd5);
    push_item(KIND_POLL, 1'b1, 32'd10);
    push_item(KIND_POLL, 1'b0, 32'd100);
    push_item(KIND_POLL, 1'b0, 32'd130);
    push_item(KIND_POLL, 1'b0, 32'd131);
    push_item(KIND_POLL, 1'b1, 32'd200);
    push_item(KIND_POLL, 1'b0, 32'd210);
    push_item(KIND_POLL, 1'b1, 32'd220);
    push_item(KIND_POLL, 1'b1, 32'd251);
    push_item(KIND_POLL, 1'b0, 32'd300);
    push_item(KIND_POLL, 1'b0, 32'd340);
    push_item(KIND_POLL, 1'b1, 32'd400);
    push_item(KIND_POLL, 1'b1, 32'd440);
    push_item(KIND_POLL, 1'b0, 32'd500);
    push_item(KIND_POLL, 1'b0, 32'd540);
    push_item(KIND_POLL, 1'b0, 32'd1339);
    push_item(KIND_POLL, 1'b0, 32'd1340);
    push_item(KIND_POLL, 1'b0, 32'd1400);
    push_item(KIND_POLL, 1'b1, 32'd1500);
    push_item(KIND_POLL, 1'b0, 32'd1450);
    push_item(KIND_POLL, 1'b0, 32'd1400);
    push_item(KIND_RESET, 1'b1, 32'hFFFF_FFF0);
    push_item(KIND_POLL, 1'b0, 32'hFFFF_FFFF);
    push_item(KIND_POLL, 1'b0, 32'h0000_0020);

    // all registers zero: long press on the poll that makes the press stable
    set_config(0, 0, 0);
    hold_asks++;
    push_item(KIND_RESET, 1'b0, 32'd0);
    push_item(KIND_POLL, 1'b0, 32'd0);
    push_item(KIND_POLL, 1'b0, 32'd1);
    push_item(KIND_POLL, 1'b1, 32'd1);
    clock_ms = 32'd1;
    random_items(300);

    // all registers at maximum, timestamps crossing the wrap
    set_config(65535, 65535, 65535);
    clock_ms = 32'hFFF0_0000;
    random_items(300);

    repeat (4) begin
      set_config($urandom_range(0, 40), $urandom_range(0, 400), $urandom_range(0, 300));
      if ($urandom_range(0, 1)) hold_asks++;
      random_items(300);
    end

    set_config($urandom_range(0, 20), $urandom_range(0, 200), $urandom_range(0, 150));
    calm = 1'b1;
    random_items(200);
    drain();
    calm = 1'b0;

    repeat (10) @(negedge clk);
    if (press_results.size() != 0) bad_count++;
    if (bad_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #8_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
